// ===== design/serial_command_frame_decoder_defines.svh =====
// Assertion macros for the serial command frame decoder.
// Included by RTL files that check their own logic; no other dependencies.
`ifndef SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset
`define SCFD_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while in reset
`define SCFD_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SCFD_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons)
`define SCFD_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons)
`endif

`endif

// ===== design/scfd_pkg.sv =====
// Types and constants for the serial command frame decoder.
// No dependencies; used by scfd_core and serial_command_frame_decoder.
`default_nettype none

package scfd_pkg;

	// Byte header codes in bits 7:6
	typedef enum logic [1:0] {
		HDR_ID     = 2'b00,
		HDR_LSB    = 2'b01,
		HDR_MSB    = 2'b10,
		HDR_TARGET = 2'b11
	} hdr_t;

	// Frame progress: bytes of the current frame held so far
	typedef enum logic [1:0] {
		STAGE_IDLE   = 2'd0,
		STAGE_ID     = 2'd1,
		STAGE_TARGET = 2'd2,
		STAGE_LSB    = 2'd3
	} stage_t;

	// Target codes acted on
	localparam logic [5:0] TGT_ROI_X     = 6'd2;
	localparam logic [5:0] TGT_ROI_Y     = 6'd3;
	localparam logic [5:0] TGT_SUBSAMPLE = 6'd4;
	localparam logic [5:0] TGT_DEVICE    = 6'd50;

	localparam logic [5:0] ID_BROADCAST = 6'd0;

	// Configuration register indexes
	localparam logic [1:0] CFG_OWN_ADDR     = 2'd0;
	localparam logic [1:0] CFG_REBOOT_KEY   = 2'd1;
	localparam logic [1:0] CFG_START_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_START_HEIGHT = 2'd3;

	localparam logic [5:0]  OWN_ADDR_RST     = 6'd1;
	localparam logic [11:0] REBOOT_KEY_RST   = 12'd0;
	localparam logic [12:0] START_WIDTH_RST  = 13'd800;
	localparam logic [12:0] START_HEIGHT_RST = 13'd608;

	// Decoder state
	typedef struct packed {
		stage_t      stage;
		logic [5:0]  held_target;
		logic [5:0]  held_low;
		logic [11:0] roi_x;
		logic [11:0] roi_y;
		logic [12:0] width;
		logic [12:0] height;
		logic        subsample;
	} state_t;

	// One result word
	typedef struct packed {
		logic        command_done;
		logic        frame_aborted;
		logic [5:0]  target_code;
		logic [11:0] command_value;
		logic [11:0] roi_x_offset;
		logic [11:0] roi_y_offset;
		logic [12:0] image_width_now;
		logic [12:0] image_height_now;
		logic        subsample_on;
		logic        roi_changed;
		logic        sensor_reinit;
		logic        restart_request;
	} result_t;

endpackage

`default_nettype wire

// ===== design/scfd_core.sv =====
// Per-byte frame decode: next state and result word from one received byte.
// Depends on scfd_pkg.
`default_nettype none

module scfd_core (
	input  wire logic [7:0]       rx_byte,
	input  wire scfd_pkg::state_t cur,
	input  wire logic [5:0]       own_addr,
	input  wire logic [11:0]      reboot_key,
	output scfd_pkg::state_t      nxt,
	output scfd_pkg::result_t     res
);

	scfd_pkg::hdr_t hdr;
	logic [5:0]     pay;
	logic [11:0]    val;
	logic           abort;
	logic           done;
	logic           roi_chg;
	logic           reinit;
	logic           restart;

	assign hdr = scfd_pkg::hdr_t'(rx_byte[7:6]);
	assign pay = rx_byte[5:0];
	assign val = {pay, cur.held_low};

	// Sequence check and command apply
	always_comb begin
		nxt     = cur;
		abort   = 1'b1;
		done    = 1'b0;
		roi_chg = 1'b0;
		reinit  = 1'b0;
		restart = 1'b0;
		case (hdr)
			scfd_pkg::HDR_ID: begin
				if (cur.stage == scfd_pkg::STAGE_IDLE &&
				    (pay == own_addr || pay == scfd_pkg::ID_BROADCAST)) begin
					nxt.stage = scfd_pkg::STAGE_ID;
					abort     = 1'b0;
				end
			end
			scfd_pkg::HDR_TARGET: begin
				if (cur.stage == scfd_pkg::STAGE_ID) begin
					nxt.stage       = scfd_pkg::STAGE_TARGET;
					nxt.held_target = pay;
					abort           = 1'b0;
				end
			end
			scfd_pkg::HDR_LSB: begin
				if (cur.stage == scfd_pkg::STAGE_TARGET) begin
					nxt.stage    = scfd_pkg::STAGE_LSB;
					nxt.held_low = pay;
					abort        = 1'b0;
				end
			end
			scfd_pkg::HDR_MSB: begin
				if (cur.stage == scfd_pkg::STAGE_LSB) begin
					nxt.stage = scfd_pkg::STAGE_IDLE;
					abort     = 1'b0;
					done      = 1'b1;
					case (cur.held_target)
						scfd_pkg::TGT_ROI_X: begin
							nxt.roi_x = val;
							roi_chg   = 1'b1;
						end
						scfd_pkg::TGT_ROI_Y: begin
							nxt.roi_y = val;
							roi_chg   = 1'b1;
						end
						scfd_pkg::TGT_SUBSAMPLE: begin
							// toggle only on a real change; doubling wraps at 13 bits
							if (!cur.subsample && val == 12'd1) begin
								nxt.width     = {cur.width[11:0], 1'b0};
								nxt.height    = {cur.height[11:0], 1'b0};
								nxt.subsample = 1'b1;
								reinit        = 1'b1;
							end else if (cur.subsample && val == 12'd0) begin
								nxt.width     = {1'b0, cur.width[12:1]};
								nxt.height    = {1'b0, cur.height[12:1]};
								nxt.subsample = 1'b0;
								reinit        = 1'b1;
							end
						end
						scfd_pkg::TGT_DEVICE: begin
							restart = (val == reboot_key);
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		if (abort) begin
			nxt.stage = scfd_pkg::STAGE_IDLE;
		end
	end

	// Result word: one-shot fields only on completion or abort, state after the byte
	always_comb begin
		res.command_done     = done;
		res.frame_aborted    = abort;
		res.target_code      = done ? cur.held_target : 6'd0;
		res.command_value    = done ? val : 12'd0;
		res.roi_x_offset     = nxt.roi_x;
		res.roi_y_offset     = nxt.roi_y;
		res.image_width_now  = nxt.width;
		res.image_height_now = nxt.height;
		res.subsample_on     = nxt.subsample;
		res.roi_changed      = roi_chg;
		res.sensor_reinit    = reinit;
		res.restart_request  = restart;
	end

endmodule

`default_nettype wire

// ===== design/serial_command_frame_decoder.sv =====
// A result word passes the input register, then the result register, after its
// byte is accepted. Throughput: one byte per cycle while the output is not stalled;
// a stall on the output holds the input register, which takes one more byte while
// a result waits, then stalls.
// Reset: frame cleared, offsets and subsample zero, size 800 x 608, device ID 1,
// restart key 0. Start size writes are taken but reset always loads 800 x 608.
`default_nettype none
`include "serial_command_frame_decoder_defines.svh"

module serial_command_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	// byte input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             command_done,
	output logic             frame_aborted,
	output logic [5:0]       target_code,
	output logic [11:0]      command_value,
	output logic [11:0]      roi_x_offset,
	output logic [11:0]      roi_y_offset,
	output logic [12:0]      image_width_now,
	output logic [12:0]      image_height_now,
	output logic             subsample_on,
	output logic             roi_changed,
	output logic             sensor_reinit,
	output logic             restart_request
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	scfd_pkg::result_t result_q;
	scfd_pkg::state_t  state_q;
	scfd_pkg::state_t  state_nxt;
	scfd_pkg::result_t result_nxt;
	logic [5:0]        own_addr_q;
	logic [11:0]       reboot_key_q;
	logic              advance;
	logic              fire_s1;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= scfd_pkg::OWN_ADDR_RST;
			reboot_key_q <= scfd_pkg::REBOOT_KEY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				scfd_pkg::CFG_OWN_ADDR:     own_addr_q   <= cfg_data[5:0];
				scfd_pkg::CFG_REBOOT_KEY:   reboot_key_q <= cfg_data;
				// start size only matters at reset, which loads the defaults
				scfd_pkg::CFG_START_WIDTH:  ;
				scfd_pkg::CFG_START_HEIGHT: ;
				default: ;
			endcase
		end
	end

	// Handshake: result register frees when empty or taken
	assign advance  = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	scfd_core u_core (
		.rx_byte    (byte_s1),
		.cur        (state_q),
		.own_addr   (own_addr_q),
		.reboot_key (reboot_key_q),
		.nxt        (state_nxt),
		.res        (result_nxt)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stage       <= scfd_pkg::STAGE_IDLE;
			state_q.held_target <= 6'd0;
			state_q.held_low    <= 6'd0;
			state_q.roi_x       <= 12'd0;
			state_q.roi_y       <= 12'd0;
			state_q.width       <= scfd_pkg::START_WIDTH_RST;
			state_q.height      <= scfd_pkg::START_HEIGHT_RST;
			state_q.subsample   <= 1'b0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign command_done     = result_q.command_done;
	assign frame_aborted    = result_q.frame_aborted;
	assign target_code      = result_q.target_code;
	assign command_value    = result_q.command_value;
	assign roi_x_offset     = result_q.roi_x_offset;
	assign roi_y_offset     = result_q.roi_y_offset;
	assign image_width_now  = result_q.image_width_now;
	assign image_height_now = result_q.image_height_now;
	assign subsample_on     = result_q.subsample_on;
	assign roi_changed      = result_q.roi_changed;
	assign sensor_reinit    = result_q.sensor_reinit;
	assign restart_request  = result_q.restart_request;

	// Checks
	`SCFD_ASSERT_IMPL(a_done_not_abort, clk, arst_n, out_valid_q, !(command_done && frame_aborted))
	`SCFD_ASSERT_IMPL(a_flags_need_done, clk, arst_n, out_valid_q && (roi_changed || sensor_reinit || restart_request), command_done)
	`SCFD_ASSERT_NEXT(a_fire_loads_out, clk, arst_n, fire_s1, out_valid_q)
	`SCFD_ASSERT_IMPL(a_stall_only_full, clk, arst_n, !in_ready, valid_s1 && out_valid_q && !out_ready)
	`SCFD_ASSERT_NEXT(a_abort_clears_frame, clk, arst_n, fire_s1 && result_nxt.frame_aborted, state_q.stage == scfd_pkg::STAGE_IDLE)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for serial_command_frame_decoder: directed frames, then random traffic.
// Needs scfd_pkg and the decoder RTL. An in-bench scoreboard predicts every result word.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// targets the block only reports
	localparam logic [5:0] TGT_LED  = 6'd0;
	localparam logic [5:0] TGT_GAIN = 6'd1;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Expected-word store plus its own model of the decoder state
	class frame_decode_board;
		logic [5:0]        own_id;
		logic [11:0]       reboot_key;
		logic [11:0]       boot_width, boot_height;
		scfd_pkg::stage_t  stage;
		logic [5:0]        tgt;
		logic [5:0]        low_part;
		logic [11:0]       roi_x, roi_y;
		logic [12:0]       width, height;
		logic              sub;
		scfd_pkg::result_t pending_words[$];
		int unsigned errors, checked, frames, aborts, toggles, restarts;

		function new();
			own_id = scfd_pkg::OWN_ADDR_RST;
			reboot_key = scfd_pkg::REBOOT_KEY_RST;
			boot_width = scfd_pkg::START_WIDTH_RST[11:0];
			boot_height = scfd_pkg::START_HEIGHT_RST[11:0];
			stage = scfd_pkg::STAGE_IDLE;
			tgt = '0;
			low_part = '0;
			roi_x = '0;
			roi_y = '0;
			// reset always loads the fixed start size
			width = scfd_pkg::START_WIDTH_RST;
			height = scfd_pkg::START_HEIGHT_RST;
			sub = 1'b0;
		endfunction

		function void set_register(logic [1:0] idx, logic [11:0] data);
			case (idx)
				scfd_pkg::CFG_OWN_ADDR: own_id = data[5:0];
				scfd_pkg::CFG_REBOOT_KEY: reboot_key = data;
				scfd_pkg::CFG_START_WIDTH: boot_width = data;
				scfd_pkg::CFG_START_HEIGHT: boot_height = data;
				default: ;
			endcase
		endfunction

		// Advance the model by one accepted byte and queue the word it causes
		function void note_byte(logic [7:0] b);
			scfd_pkg::result_t w;
			scfd_pkg::hdr_t hdr;
			logic [5:0] pay;
			hdr = scfd_pkg::hdr_t'(b[7:6]);
			pay = b[5:0];
			w = '0;
			if (hdr == scfd_pkg::HDR_ID && stage == scfd_pkg::STAGE_IDLE &&
			    (pay == own_id || pay == scfd_pkg::ID_BROADCAST)) begin
				stage = scfd_pkg::STAGE_ID;
			end else if (hdr == scfd_pkg::HDR_TARGET && stage == scfd_pkg::STAGE_ID) begin
				tgt = pay;
				stage = scfd_pkg::STAGE_TARGET;
			end else if (hdr == scfd_pkg::HDR_LSB && stage == scfd_pkg::STAGE_TARGET) begin
				low_part = pay;
				stage = scfd_pkg::STAGE_LSB;
			end else if (hdr == scfd_pkg::HDR_MSB && stage == scfd_pkg::STAGE_LSB) begin
				w.command_value = {pay, low_part};
				w.target_code = tgt;
				w.command_done = 1'b1;
				stage = scfd_pkg::STAGE_IDLE;
				frames++;
				if (tgt == scfd_pkg::TGT_ROI_X) begin
					roi_x = w.command_value;
					w.roi_changed = 1'b1;
				end else if (tgt == scfd_pkg::TGT_ROI_Y) begin
					roi_y = w.command_value;
					w.roi_changed = 1'b1;
				end else if (tgt == scfd_pkg::TGT_SUBSAMPLE) begin
					// only a real 0->1 or 1->0 change resizes
					if (!sub && w.command_value == 12'd1) begin
						width = {width[11:0], 1'b0};
						height = {height[11:0], 1'b0};
						sub = 1'b1;
						w.sensor_reinit = 1'b1;
					end else if (sub && w.command_value == 12'd0) begin
						width = width >> 1;
						height = height >> 1;
						sub = 1'b0;
						w.sensor_reinit = 1'b1;
					end
					toggles += w.sensor_reinit;
				end else if (tgt == scfd_pkg::TGT_DEVICE) begin
					w.restart_request = (w.command_value == reboot_key);
					restarts += w.restart_request;
				end
			end else begin
				stage = scfd_pkg::STAGE_IDLE;
				w.frame_aborted = 1'b1;
				aborts++;
			end
			w.roi_x_offset = roi_x;
			w.roi_y_offset = roi_y;
			w.image_width_now = width;
			w.image_height_now = height;
			w.subsample_on = sub;
			pending_words.push_back(w);
		endfunction

		function void compare_field(string name, logic [12:0] want, logic [12:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(scfd_pkg::result_t got);
			scfd_pkg::result_t want;
			if (pending_words.size() == 0) begin
				$error("result word with no byte outstanding");
				errors++;
				return;
			end
			want = pending_words.pop_front();
			checked++;
			compare_field("command_done", want.command_done, got.command_done);
			compare_field("frame_aborted", want.frame_aborted, got.frame_aborted);
			compare_field("target_code", want.target_code, got.target_code);
			compare_field("command_value", want.command_value, got.command_value);
			compare_field("roi_x_offset", want.roi_x_offset, got.roi_x_offset);
			compare_field("roi_y_offset", want.roi_y_offset, got.roi_y_offset);
			compare_field("image_width_now", want.image_width_now, got.image_width_now);
			compare_field("image_height_now", want.image_height_now, got.image_height_now);
			compare_field("subsample_on", want.subsample_on, got.subsample_on);
			compare_field("roi_changed", want.roi_changed, got.roi_changed);
			compare_field("sensor_reinit", want.sensor_reinit, got.sensor_reinit);
			compare_field("restart_request", want.restart_request, got.restart_request);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        command_done, frame_aborted;
	logic [5:0]  target_code;
	logic [11:0] command_value, roi_x_offset, roi_y_offset;
	logic [12:0] image_width_now, image_height_now;
	logic        subsample_on, roi_changed, sensor_reinit, restart_request;

	frame_decode_board board = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycles = 0;

	serial_command_frame_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.command_done(command_done), .frame_aborted(frame_aborted),
		.target_code(target_code), .command_value(command_value),
		.roi_x_offset(roi_x_offset), .roi_y_offset(roi_y_offset),
		.image_width_now(image_width_now), .image_height_now(image_height_now),
		.subsample_on(subsample_on), .roi_changed(roi_changed),
		.sensor_reinit(sensor_reinit), .restart_request(restart_request)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: sample pre-edge values, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_word('{command_done: command_done, frame_aborted: frame_aborted,
				target_code: target_code, command_value: command_value,
				roi_x_offset: roi_x_offset, roi_y_offset: roi_y_offset,
				image_width_now: image_width_now, image_height_now: image_height_now,
				subsample_on: subsample_on, roi_changed: roi_changed,
				sensor_reinit: sensor_reinit, restart_request: restart_request});
		end
		out_ready <= arst_n ? ($urandom_range(0, 99) >= recv_idle_pct) : 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycles, board.pending_words.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// Send one byte; returns in the step of its acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	// First `keep` bytes of a frame; fewer than four leaves it broken
	task automatic send_frame(input logic [5:0] id, input logic [5:0] tgt,
			input logic [11:0] value, input int unsigned keep);
		logic [7:0] seq [4];
		seq[0] = {scfd_pkg::HDR_ID, id};
		seq[1] = {scfd_pkg::HDR_TARGET, tgt};
		seq[2] = {scfd_pkg::HDR_LSB, value[5:0]};
		seq[3] = {scfd_pkg::HDR_MSB, value[11:6]};
		for (int k = 0; k < keep; k++)
			send_byte(seq[k]);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [11:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(idx, data);
	endtask

	task automatic configure(input logic [5:0] id, input logic [11:0] key,
			input logic [11:0] w, input logic [11:0] h);
		write_register(scfd_pkg::CFG_OWN_ADDR, {6'd0, id});
		write_register(scfd_pkg::CFG_REBOOT_KEY, key);
		write_register(scfd_pkg::CFG_START_WIDTH, w);
		write_register(scfd_pkg::CFG_START_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait for every expected word, plus pipeline slack
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [5:0] pick_id();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return board.own_id;
			4, 5, 6, 7: return scfd_pkg::ID_BROADCAST;
			default: return 6'($urandom);
		endcase
	endfunction

	function automatic logic [5:0] pick_target();
		case ($urandom_range(0, 8))
			0: return TGT_LED;
			1: return TGT_GAIN;
			2: return scfd_pkg::TGT_ROI_X;
			3: return scfd_pkg::TGT_ROI_Y;
			4, 5: return scfd_pkg::TGT_SUBSAMPLE;
			6, 7: return scfd_pkg::TGT_DEVICE;
			default: return 6'($urandom);
		endcase
	endfunction

	// Bias values toward the ones that trigger side effects
	function automatic logic [11:0] pick_value(input logic [5:0] tgt);
		if (tgt == scfd_pkg::TGT_SUBSAMPLE && $urandom_range(0, 3) != 0)
			return 12'($urandom_range(0, 1));
		if (tgt == scfd_pkg::TGT_DEVICE && $urandom_range(0, 1) != 0)
			return board.reboot_key;
		return 12'($urandom);
	endfunction

	// Mostly well-formed frames, some cut short, some raw noise
	task automatic run_random(input int unsigned count);
		int unsigned stop;
		int unsigned roll;
		logic [5:0] tgt;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			roll = $urandom_range(0, 99);
			tgt = pick_target();
			if (roll < 72)
				send_frame(pick_id(), tgt, pick_value(tgt), 4);
			else if (roll < 87)
				send_frame(pick_id(), tgt, pick_value(tgt), $urandom_range(1, 3));
			else
				send_byte(8'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 32%, receiver 57%
		send_idle_pct = 32;
		recv_idle_pct = 57;
		configure(6'd37, 12'd2730, 12'd4095, 12'd1);

		// directed: aborts at idle, extremes, ROI X, subsample on and off, restart
		send_byte({scfd_pkg::HDR_TARGET, 6'd5});
		send_frame(scfd_pkg::ID_BROADCAST, scfd_pkg::TGT_ROI_X, 12'd4095, 4);
		send_frame(6'd37, scfd_pkg::TGT_SUBSAMPLE, 12'd1, 4);
		send_frame(scfd_pkg::ID_BROADCAST, scfd_pkg::TGT_SUBSAMPLE, 12'd1, 4);
		send_frame(6'd37, scfd_pkg::TGT_SUBSAMPLE, 12'd0, 4);
		send_frame(6'd37, scfd_pkg::TGT_DEVICE, 12'd2730, 4);
		send_byte({scfd_pkg::HDR_ID, 6'd63});
		send_frame(6'd37, TGT_GAIN, 12'd0, 2);
		send_byte({scfd_pkg::HDR_ID, 6'd37});
		run_random(500);
		settle();

		// roles swapped
		send_idle_pct = 57;
		recv_idle_pct = 32;
		configure(6'd0, 12'd0, 12'd1, 12'd4095);
		run_random(500);
		settle();

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(6'd63, 12'd4095, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
		run_random(450);
		settle();

		configure(6'($urandom_range(1, 62)), 12'($urandom), 12'($urandom_range(1, 4095)),
			12'($urandom_range(1, 4095)));
		run_random(200);
		settle();

		if (board.pending_words.size() != 0) begin
			$error("%0d expected words never arrived", board.pending_words.size());
			board.errors++;
		end
		$display("summary: %0d bytes, %0d words checked, %0d frames, %0d aborts",
			bytes_sent, board.checked, board.frames, board.aborts);
		$display("summary: %0d subsample toggles, %0d restart hits, four register settings",
			board.toggles, board.restarts);
		if (board.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
